// ===== src/tli_pkg.sv =====
// Shared constants, widths and types of the triangle Lagrange interpolator.
package tli_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int NODES     = 6;
    localparam int VERTS     = 3;

    // Front-end area arithmetic
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int AREA_W = PROD_W + 1;
    localparam int MAG_W  = AREA_W;
    localparam int AREAS  = VERTS + 1;

    // Weight divider
    localparam int NUM_W      = MAG_W + FRAC_BITS + 2;
    localparam int DEN_W      = MAG_W + 1;
    localparam int QUO_W      = 32;
    localparam int DIV_STAGES = QUO_W;
    localparam int WLIM_W     = QUO_W + 1;
    localparam logic [WLIM_W-1:0] WLIM_POS = WLIM_W'((64'd1 << (VAL_W - 1)) - 64'd1);
    localparam logic [WLIM_W-1:0] WLIM_NEG = WLIM_W'(64'd1 << (VAL_W - 1));

    // Back-end products and sums
    localparam int LP_W    = 2 * VAL_W;
    localparam int LIN_W   = LP_W + 2;
    localparam int PHI_A_W = VAL_W + 2;
    localparam int PHI_W   = PHI_A_W + VAL_W;
    localparam int SPLIT_W = PHI_W / 2;
    localparam int PPL_W   = SPLIT_W + 1 + VAL_W;
    localparam int PPH_W   = PHI_W - SPLIT_W + VAL_W;
    localparam int ACC_W   = 100;

    // Vertex average, divide by three through a reciprocal
    localparam int SUM_W     = VAL_W + 2;
    localparam int AVG_W     = VAL_W + 1;
    localparam int AVG_MUL_W = 33;
    localparam int AVG_SH    = 34;
    localparam int AVGP_W    = AVG_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL = 33'h1_5555_5556;

    // Interpolation order codes
    localparam int ORDER_W = 2;
    localparam logic [ORDER_W-1:0] ORDER_LIN  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_QUAD = 2'd2;

    // Register map
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_V0X   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_V0Y   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_V1X   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_V1Y   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_V2X   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_V2Y   = 3'd6;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [VAL_W-1:0]   v0x;
        logic [VAL_W-1:0]   v0y;
        logic [VAL_W-1:0]   v1x;
        logic [VAL_W-1:0]   v1y;
        logic [VAL_W-1:0]   v2x;
        logic [VAL_W-1:0]   v2y;
    } t_cfg;

    typedef struct packed {
        logic                        quad;
        logic                        degen;
        logic [NODES-1:0][VAL_W-1:0] val;
        logic [VERTS-1:0][NUM_W-1:0] num;
        logic [VERTS-1:0]            neg;
        logic [VERTS-1:0]            ovf;
        logic [DEN_W-1:0]            den2;
    } t_item;

endpackage

// ===== src/tli_if.sv =====
// Valid/ready channel interfaces for query beats and result beats.
interface tli_in_if import tli_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] pt_x;
    logic [VAL_W-1:0] pt_y;
    logic [VAL_W-1:0] node_value_0;
    logic [VAL_W-1:0] node_value_1;
    logic [VAL_W-1:0] node_value_2;
    logic [VAL_W-1:0] node_value_3;
    logic [VAL_W-1:0] node_value_4;
    logic [VAL_W-1:0] node_value_5;

    modport source (
        output valid, pt_x, pt_y, node_value_0, node_value_1, node_value_2,
               node_value_3, node_value_4, node_value_5,
        input  ready
    );
    modport sink (
        input  valid, pt_x, pt_y, node_value_0, node_value_1, node_value_2,
               node_value_3, node_value_4, node_value_5,
        output ready
    );
endinterface

interface tli_out_if import tli_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] low_order;
    logic [VAL_W-1:0] high_order;
    logic             degenerate;
    logic             saturated;

    modport source (
        output valid, low_order, high_order, degenerate, saturated,
        input  ready
    );
    modport sink (
        input  valid, low_order, high_order, degenerate, saturated,
        output ready
    );
endinterface

// ===== src/tli_front.sv =====
// Front end: accept query beats, form signed doubled areas and divider operands.
module tli_front import tli_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    tli_in_if.sink i_in,
    input  logic   i_q_ready,
    output logic   o_push,
    output t_item  o_item
);

    logic adv;
    logic take;

    logic [3:0] r_vld;
    logic       r_quad [4];
    logic [NODES-1:0][VAL_W-1:0] r_val [4];

    logic signed [DIFF_W-1:0] n_d  [AREAS][4];
    logic signed [DIFF_W-1:0] r_d  [AREAS][4];
    logic signed [PROD_W-1:0] r_m  [AREAS][2];
    logic signed [AREA_W-1:0] r_a  [AREAS];
    logic        [MAG_W-1:0]  r_mag [AREAS];
    logic        [VERTS-1:0]  r_neg;
    logic                     r_degen;

    logic signed [VAL_W-1:0] px, py, x0, y0, x1, y1, x2, y2;

    // Advance while the queue has room or the last stage is empty
    assign adv        = i_q_ready || !r_vld[3];
    assign take       = i_in.valid && adv;
    assign i_in.ready = adv;

    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    // Edge differences for the triangle area and the three sub-areas
    always_comb begin
        px = $signed(i_in.pt_x);
        py = $signed(i_in.pt_y);
        x0 = $signed(i_cfg.v0x);
        y0 = $signed(i_cfg.v0y);
        x1 = $signed(i_cfg.v1x);
        y1 = $signed(i_cfg.v1y);
        x2 = $signed(i_cfg.v2x);
        y2 = $signed(i_cfg.v2y);
        // whole triangle (v0, v1, v2)
        n_d[0][0] = sub_ext(x1, x0);
        n_d[0][1] = sub_ext(y2, y0);
        n_d[0][2] = sub_ext(x2, x0);
        n_d[0][3] = sub_ext(y1, y0);
        // (p, v1, v2)
        n_d[1][0] = sub_ext(x1, px);
        n_d[1][1] = sub_ext(y2, py);
        n_d[1][2] = sub_ext(x2, px);
        n_d[1][3] = sub_ext(y1, py);
        // (p, v2, v0)
        n_d[2][0] = sub_ext(x2, px);
        n_d[2][1] = sub_ext(y0, py);
        n_d[2][2] = sub_ext(x0, px);
        n_d[2][3] = sub_ext(y2, py);
        // (p, v0, v1)
        n_d[3][0] = sub_ext(x0, px);
        n_d[3][1] = sub_ext(y1, py);
        n_d[3][2] = sub_ext(x1, px);
        n_d[3][3] = sub_ext(y0, py);
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[2:0], take};
        end
    end

    // Pipeline payload: differences, products, areas, magnitudes
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_quad[0] <= (i_cfg.order == ORDER_QUAD);
            r_val[0]  <= {i_in.node_value_5, i_in.node_value_4, i_in.node_value_3,
                          i_in.node_value_2, i_in.node_value_1, i_in.node_value_0};
            for (int s = 1; s < 4; s++) begin
                r_quad[s] <= r_quad[s-1];
                r_val[s]  <= r_val[s-1];
            end
            for (int k = 0; k < AREAS; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r_d[k][j] <= n_d[k][j];
                end
                r_m[k][0] <= r_d[k][0] * r_d[k][1];
                r_m[k][1] <= r_d[k][2] * r_d[k][3];
                r_a[k]    <= AREA_W'(r_m[k][0]) - AREA_W'(r_m[k][1]);
                r_mag[k]  <= r_a[k][AREA_W-1] ? MAG_W'(-r_a[k]) : MAG_W'(r_a[k]);
            end
            for (int l = 0; l < VERTS; l++) begin
                r_neg[l] <= r_a[l+1][AREA_W-1] ^ r_a[0][AREA_W-1];
            end
            r_degen <= (r_a[0] == '0);
        end
    end

    // Build divider operands and flag quotients too large for the weight range
    always_comb begin
        o_item.quad  = r_quad[3];
        o_item.degen = r_degen;
        o_item.val   = r_val[3];
        o_item.neg   = r_neg;
        o_item.den2  = DEN_W'(r_mag[0]) << 1;
        for (int l = 0; l < VERTS; l++) begin
            o_item.num[l] = (NUM_W'(r_mag[l+1]) << (FRAC_BITS + 1)) + NUM_W'(r_mag[0]);
            o_item.ovf[l] = DEN_W'(o_item.num[l][NUM_W-1:QUO_W]) >= o_item.den2;
        end
    end

    assign o_push = r_vld[3] && i_q_ready;

endmodule

// ===== src/tli_queue.sv =====
// Short FIFO that decouples the front end from the back end.
module tli_queue import tli_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr - r_rd) == r_cnt[QPTR_W-1:0])
        else $error("pointer gap disagrees with count");

endmodule

// ===== src/tli_back.sv =====
// Back end: pipelined weight division, basis products, sums, rounding, clamping.
module tli_back import tli_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_item,
    output logic       o_pop,
    tli_out_if.source  o_out
);

    typedef struct packed {
        logic                        quad;
        logic                        degen;
        logic [NODES-1:0][VAL_W-1:0] val;
        logic [VERTS-1:0]            neg;
        logic [VERTS-1:0]            ovf;
        logic [DEN_W-1:0]            den2;
        logic [VERTS-1:0][DEN_W-1:0] rem;
        logic [VERTS-1:0][QUO_W-1:0] lo;
        logic [VERTS-1:0][QUO_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic                        quad;
        logic                        degen;
        logic                        wsat;
        logic                        s_neg;
        logic [NODES-1:0][VAL_W-1:0] val;
        logic [VERTS-1:0][VAL_W-1:0] lw;
        logic [AVG_W-1:0]            ax;
    } t_b0;

    typedef struct packed {
        logic                        quad;
        logic                        degen;
        logic                        wsat;
        logic                        s_neg;
        logic [NODES-1:0][VAL_W-1:0] val;
        logic [VERTS-1:0][LP_W-1:0]  lp;
        logic [NODES-1:0][PHI_W-1:0] phi;
        logic [AVGP_W-1:0]           avg_p;
    } t_b1;

    typedef struct packed {
        logic                        quad;
        logic                        degen;
        logic                        wsat;
        logic [LIN_W-1:0]            lin_sum;
        logic [VAL_W-1:0]            avg;
        logic [NODES-1:0][PPL_W-1:0] pp_lo;
        logic [NODES-1:0][PPH_W-1:0] pp_hi;
    } t_b2;

    typedef struct packed {
        logic                        quad;
        logic                        degen;
        logic                        wsat;
        logic [LIN_W-1:0]            lin_r;
        logic [VAL_W-1:0]            avg;
        logic [NODES-1:0][ACC_W-1:0] term;
    } t_b3;

    typedef struct packed {
        logic             quad;
        logic             degen;
        logic             wsat;
        logic [LIN_W-1:0] lin_r;
        logic [VAL_W-1:0] avg;
        logic [ACC_W-1:0] acc;
    } t_b4;

    localparam logic signed [PHI_A_W-1:0] ONE_Q    = PHI_A_W'(64'd1 << FRAC_BITS);
    localparam logic signed [LIN_W-1:0]   LIN_HALF = LIN_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]   ACC_HALF = ACC_W'(64'd1 << (2 * FRAC_BITS - 1));

    logic adv;

    t_div               r_div [DIV_STAGES+1];
    logic [DIV_STAGES:0] r_dv;
    t_b0  n_b0, r_b0;
    t_b1  n_b1, r_b1;
    t_b2  n_b2, r_b2;
    t_b3  n_b3, r_b3;
    t_b4  n_b4, r_b4;
    logic [4:0] r_bv;

    logic             r_ov;
    logic [VAL_W-1:0] r_low;
    logic [VAL_W-1:0] r_high;
    logic             r_degen;
    logic             r_sat;
    logic [VAL_W-1:0] n_low;
    logic [VAL_W-1:0] n_high;
    logic             n_sat;

    // Whole back pipeline moves when the output register is free or being drained
    assign adv   = !r_ov || o_out.ready;
    assign o_pop = i_q_valid && adv;

    function automatic t_div div_entry(input t_item it);
        t_div r;
        r.quad  = it.quad;
        r.degen = it.degen;
        r.val   = it.val;
        r.neg   = it.neg;
        r.ovf   = it.ovf;
        r.den2  = it.den2;
        for (int l = 0; l < VERTS; l++) begin
            r.rem[l] = DEN_W'(it.num[l][NUM_W-1:QUO_W]);
            r.lo[l]  = it.num[l][QUO_W-1:0];
            r.quo[l] = '0;
        end
        return r;
    endfunction

    // One restoring-division step per lane
    function automatic t_div div_step(input t_div s);
        t_div           r;
        logic [DEN_W:0] t;
        logic           ge;
        r = s;
        for (int l = 0; l < VERTS; l++) begin
            t  = {s.rem[l], s.lo[l][QUO_W-1]};
            ge = (t >= {1'b0, s.den2});
            r.rem[l] = ge ? DEN_W'(t - {1'b0, s.den2}) : t[DEN_W-1:0];
            r.lo[l]  = {s.lo[l][QUO_W-2:0], 1'b0};
            r.quo[l] = {s.quo[l][QUO_W-2:0], ge};
        end
        return r;
    endfunction

    // Clamp to 32-bit signed; top bit of the result flags a clamp
    function automatic logic [VAL_W:0] clamp32(input logic [ACC_W-1:0] v);
        logic [ACC_W-VAL_W:0] hi;
        hi = v[ACC_W-1:VAL_W-1];
        if (&hi || !(|hi)) begin
            return {1'b0, v[VAL_W-1:0]};
        end
        return v[ACC_W-1] ? {1'b1, 1'b1, {(VAL_W-1){1'b0}}}
                          : {1'b1, 1'b0, {(VAL_W-1){1'b1}}};
    endfunction

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_dv <= {r_dv[DIV_STAGES-1:0], o_pop};
            r_bv <= {r_bv[3:0], r_dv[DIV_STAGES]};
            r_ov <= r_bv[4];
        end
    end

    // Divider pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_div[0] <= div_entry(i_item);
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_div[k+1] <= div_step(r_div[k]);
            end
        end
    end

    // Weights: sign, clamp; vertex sum for the average
    always_comb begin
        logic [WLIM_W-1:0]       q;
        logic [WLIM_W-1:0]       lim;
        logic [WLIM_W-1:0]       m;
        logic [WLIM_W-1:0]       sg;
        logic                    ws;
        logic signed [SUM_W-1:0] s;
        logic [SUM_W-1:0]        ms;
        n_b0.quad  = r_div[DIV_STAGES].quad;
        n_b0.degen = r_div[DIV_STAGES].degen;
        n_b0.val   = r_div[DIV_STAGES].val;
        n_b0.wsat  = 1'b0;
        for (int l = 0; l < VERTS; l++) begin
            q   = {1'b0, r_div[DIV_STAGES].quo[l]};
            lim = r_div[DIV_STAGES].neg[l] ? WLIM_NEG : WLIM_POS;
            ws  = r_div[DIV_STAGES].ovf[l] || (q > lim);
            m   = ws ? lim : q;
            sg  = r_div[DIV_STAGES].neg[l] ? -m : m;
            n_b0.lw[l] = sg[VAL_W-1:0];
            n_b0.wsat  = n_b0.wsat | ws;
        end
        s = SUM_W'($signed(r_div[DIV_STAGES].val[0]))
          + SUM_W'($signed(r_div[DIV_STAGES].val[1]))
          + SUM_W'($signed(r_div[DIV_STAGES].val[2]));
        ms = s[SUM_W-1] ? -s : s;
        n_b0.s_neg = s[SUM_W-1];
        n_b0.ax    = AVG_W'(ms) + 1'b1;
    end

    // Linear terms, quadratic basis functions, average reciprocal product
    always_comb begin
        logic signed [LP_W-1:0]    p;
        logic signed [PHI_A_W-1:0] a;
        logic signed [PHI_W-1:0]   ph;
        logic [AVGP_W-1:0]         ap;
        n_b1.quad  = r_b0.quad;
        n_b1.degen = r_b0.degen;
        n_b1.wsat  = r_b0.wsat;
        n_b1.s_neg = r_b0.s_neg;
        n_b1.val   = r_b0.val;
        for (int l = 0; l < VERTS; l++) begin
            p  = $signed(r_b0.lw[l]) * $signed(r_b0.val[l]);
            n_b1.lp[l] = p;
            a  = (PHI_A_W'($signed(r_b0.lw[l])) <<< 1) - ONE_Q;
            ph = a * $signed(r_b0.lw[l]);
            n_b1.phi[l] = ph;
            a  = PHI_A_W'($signed(r_b0.lw[l])) <<< 2;
            ph = a * $signed(r_b0.lw[(l + 1) % VERTS]);
            n_b1.phi[l + VERTS] = ph;
        end
        ap = AVGP_W'(r_b0.ax) * AVGP_W'(AVG_MUL);
        n_b1.avg_p = ap;
    end

    // Linear sum, average quotient, split basis-times-value products
    always_comb begin
        logic signed [LIN_W-1:0] ls;
        logic [VAL_W-1:0]        q;
        logic signed [PPL_W-1:0] pl;
        logic signed [PPH_W-1:0] phh;
        n_b2.quad  = r_b1.quad;
        n_b2.degen = r_b1.degen;
        n_b2.wsat  = r_b1.wsat;
        ls = '0;
        for (int l = 0; l < VERTS; l++) begin
            ls = ls + LIN_W'($signed(r_b1.lp[l]));
        end
        n_b2.lin_sum = ls;
        q = r_b1.avg_p[AVG_SH +: VAL_W];
        n_b2.avg = r_b1.s_neg ? -q : q;
        for (int i = 0; i < NODES; i++) begin
            pl  = $signed({1'b0, r_b1.phi[i][SPLIT_W-1:0]}) * $signed(r_b1.val[i]);
            phh = $signed(r_b1.phi[i][PHI_W-1:SPLIT_W]) * $signed(r_b1.val[i]);
            n_b2.pp_lo[i] = pl;
            n_b2.pp_hi[i] = phh;
        end
    end

    // Recombine partial products; round the linear result
    always_comb begin
        logic signed [ACC_W-1:0] t;
        logic signed [LIN_W-1:0] lr;
        n_b3.quad  = r_b2.quad;
        n_b3.degen = r_b2.degen;
        n_b3.wsat  = r_b2.wsat;
        n_b3.avg   = r_b2.avg;
        lr = ($signed(r_b2.lin_sum) + LIN_HALF) >>> FRAC_BITS;
        n_b3.lin_r = lr;
        for (int i = 0; i < NODES; i++) begin
            t = (ACC_W'($signed(r_b2.pp_hi[i])) <<< SPLIT_W)
              + ACC_W'($signed(r_b2.pp_lo[i]));
            n_b3.term[i] = t;
        end
    end

    // Sum the quadratic terms
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        n_b4.quad  = r_b3.quad;
        n_b4.degen = r_b3.degen;
        n_b4.wsat  = r_b3.wsat;
        n_b4.avg   = r_b3.avg;
        n_b4.lin_r = r_b3.lin_r;
        acc = '0;
        for (int i = 0; i < NODES; i++) begin
            acc = acc + $signed(r_b3.term[i]);
        end
        n_b4.acc = acc;
    end

    // Round, clamp and pick the result pair for the order
    always_comb begin
        logic signed [ACC_W-1:0] hq;
        logic [VAL_W:0]          cl;
        logic [VAL_W:0]          ch;
        hq = ($signed(r_b4.acc) + ACC_HALF) >>> (2 * FRAC_BITS);
        cl = clamp32(ACC_W'($signed(r_b4.lin_r)));
        ch = clamp32(hq);
        if (r_b4.degen) begin
            n_low  = '0;
            n_high = '0;
            n_sat  = 1'b0;
        end else if (r_b4.quad) begin
            n_low  = cl[VAL_W-1:0];
            n_high = ch[VAL_W-1:0];
            n_sat  = r_b4.wsat | cl[VAL_W] | ch[VAL_W];
        end else begin
            n_low  = r_b4.avg;
            n_high = cl[VAL_W-1:0];
            n_sat  = r_b4.wsat | cl[VAL_W];
        end
    end

    // Back stage payload and output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b0    <= n_b0;
            r_b1    <= n_b1;
            r_b2    <= n_b2;
            r_b3    <= n_b3;
            r_b4    <= n_b4;
            r_low   <= n_low;
            r_high  <= n_high;
            r_degen <= r_b4.degen;
            r_sat   <= n_sat;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.low_order  = r_low;
    assign o_out.high_order = r_high;
    assign o_out.degenerate = r_degen;
    assign o_out.saturated  = r_sat;

endmodule

// ===== src/triangle_lagrange_interpolator.sv =====
// Top level: register port, front end, queue and back end of the interpolator.
//
// Takes one query beat (point and six node values) per clock and returns one
// result beat per query, in order; throughput is one beat per cycle while the
// result side does not stall. A query passes four front stages for the area
// products, the four-entry queue, the barycentric weight divider, which resolves
// one quotient bit per stage for all three weights, then five stages of basis
// products and sums and the output register. The vertex coordinates and the order
// are read from the registers when a query is accepted, so write them only while
// the block is empty. A zero-area triangle gives zero results with degenerate set.
module triangle_lagrange_interpolator import tli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    tli_in_if.sink             i_in,
    tli_out_if.source          o_out
);

    t_cfg r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic cfg_wr;

    logic  q_push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    t_item front_item;
    t_item back_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order <= ORDER_LIN;
            r_cfg.v0x   <= '0;
            r_cfg.v0y   <= '0;
            r_cfg.v1x   <= VAL_W'(64'd1 << FRAC_BITS);
            r_cfg.v1y   <= '0;
            r_cfg.v2x   <= '0;
            r_cfg.v2y   <= VAL_W'(64'd1 << FRAC_BITS);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ORDER: begin
                    r_cfg.order <= pwdata[ORDER_W-1:0];
                end
                REG_V0X: begin
                    r_cfg.v0x <= pwdata[VAL_W-1:0];
                end
                REG_V0Y: begin
                    r_cfg.v0y <= pwdata[VAL_W-1:0];
                end
                REG_V1X: begin
                    r_cfg.v1x <= pwdata[VAL_W-1:0];
                end
                REG_V1Y: begin
                    r_cfg.v1y <= pwdata[VAL_W-1:0];
                end
                REG_V2X: begin
                    r_cfg.v2x <= pwdata[VAL_W-1:0];
                end
                REG_V2Y: begin
                    r_cfg.v2y <= pwdata[VAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_ORDER: prdata = PDATA_W'(r_cfg.order);
            REG_V0X:   prdata = r_cfg.v0x;
            REG_V0Y:   prdata = r_cfg.v0y;
            REG_V1X:   prdata = r_cfg.v1x;
            REG_V1Y:   prdata = r_cfg.v1y;
            REG_V2X:   prdata = r_cfg.v2x;
            REG_V2Y:   prdata = r_cfg.v2y;
            default:   prdata = '0;
        endcase
    end

    tli_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_item    (front_item)
    );

    tli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (back_item)
    );

    tli_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (back_item),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
